@@ rtl/core/ascii_integer_parser_macros.svh @@
// Assertion macros shared by the checker of the string-to-integer block.
`ifndef ASCII_INTEGER_PARSER_MACROS_SVH
`define ASCII_INTEGER_PARSER_MACROS_SVH

// Consequent checked in the clock after the antecedent; expects clk and rst_n in scope.
`define AIP_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Consequent checked in the same clock as the antecedent.
`define AIP_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/aip_pkg.sv @@
// Shared types, constants and decode functions of the string-to-integer parser.
`timescale 1ns / 1ps
`default_nettype none

package aip_pkg;

    localparam int WORD_BITS_DEF   = 64;
    localparam int OFFSET_BITS_DEF = 16;

    localparam int CHAR_W       = 8;
    localparam int RADIX_W      = 6;
    localparam int VALUE_W      = 64;
    localparam int OFFSET_OUT_W = 16;

    // character codes
    localparam logic [CHAR_W-1:0] CH_SP    = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
    localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
    localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;
    localparam logic [CHAR_W-1:0] LETTER_OFS = 8'd10;

    // bases
    localparam logic [RADIX_W-1:0] RADIX_AUTO = 6'd0;
    localparam logic [RADIX_W-1:0] MIN_BASE   = 6'd2;
    localparam logic [RADIX_W-1:0] OCT_BASE   = 6'd8;
    localparam logic [RADIX_W-1:0] DEC_BASE   = 6'd10;
    localparam logic [RADIX_W-1:0] HEX_BASE   = 6'd16;
    localparam logic [RADIX_W-1:0] MAX_BASE   = 6'd36;

    // command codes, controller to datapath
    localparam logic [1:0] SGN_KEEP  = 2'd0;
    localparam logic [1:0] SGN_PLUS  = 2'd1;
    localparam logic [1:0] SGN_MINUS = 2'd2;

    localparam logic [2:0] BASE_KEEP  = 3'd0;
    localparam logic [2:0] BASE_FIRST = 3'd1;   // radix, or ten when automatic
    localparam logic [2:0] BASE_RADIX = 3'd2;   // radix as written
    localparam logic [2:0] BASE_ZERO  = 3'd3;   // octal after a bare leading zero in automatic mode, else hex
    localparam logic [2:0] BASE_HEX   = 3'd4;

    localparam logic [1:0] ACC_KEEP  = 2'd0;
    localparam logic [1:0] ACC_CLEAR = 2'd1;
    localparam logic [1:0] ACC_DIGIT = 2'd2;

    localparam logic [2:0] EMIT_NONE    = 3'd0;
    localparam logic [2:0] EMIT_ZERO    = 3'd1;
    localparam logic [2:0] EMIT_PLAIN   = 3'd2;
    localparam logic [2:0] EMIT_SAT     = 3'd3;
    localparam logic [2:0] EMIT_HEXFAIL = 3'd4;

    typedef struct packed {
        logic                ok;
        logic [RADIX_W-1:0]  val;
    } dig_t;

    typedef struct packed {
        logic       load;
        logic       step;
        logic       idx_inc;
        logic [1:0] sign_op;
        logic [2:0] base_op;
        logic [1:0] acc_op;
        logic [2:0] emit_op;
    } cmd_t;

    typedef struct packed {
        logic start;
        logic white;
        logic plus;
        logic minus;
        logic zero_ch;
        logic x_ch;
        logic radix_0_or_16;
        logic use_fc;
        logic use_zero;
        logic use_hex;
        logic use_used;
        logic over;
        logic out_stall;
    } sts_t;

    function automatic dig_t digit_of(input logic [CHAR_W-1:0] c);
        dig_t d;
        d.ok  = 1'b1;
        d.val = '0;
        if (c inside {[CH_0:CH_9]})
            d.val = RADIX_W'(c - CH_0);
        else if (c inside {[CH_UA:CH_UZ]})
            d.val = RADIX_W'(c - CH_UA + LETTER_OFS);
        else if (c inside {[CH_LA:CH_LZ]})
            d.val = RADIX_W'(c - CH_LA + LETTER_OFS);
        else
            d.ok = 1'b0;
        return d;
    endfunction

    function automatic logic usable(input dig_t d, input logic [RADIX_W-1:0] base);
        return d.ok && (base >= MIN_BASE) && (base <= MAX_BASE) && (d.val < base);
    endfunction

    function automatic logic is_white(input logic [CHAR_W-1:0] c);
        return (c == CH_SP) || (c inside {[CH_TAB:CH_CR]});
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/aip_char_if.sv @@
// Character channel: one string character per item, with a start-of-string flag.
`timescale 1ns / 1ps
`default_nettype none

interface aip_char_if;
    logic                       valid;
    logic                       ready;
    logic [aip_pkg::CHAR_W-1:0] ch;
    logic                       start_req;

    modport source (output valid, output ch, output start_req, input ready);
    modport sink   (input valid, input ch, input start_req, output ready);
endinterface

`default_nettype wire

@@ rtl/core/aip_result_if.sv @@
// Result channel: converted value, stop offset and overflow flag per item.
`timescale 1ns / 1ps
`default_nettype none

interface aip_result_if;
    logic                             valid;
    logic                             ready;
    logic [aip_pkg::VALUE_W-1:0]      value;
    logic [aip_pkg::OFFSET_OUT_W-1:0] stop_offset;
    logic                             overflowed;

    modport source (output valid, output value, output stop_offset, output overflowed,
                    input ready);
    modport sink   (input valid, input value, input stop_offset, input overflowed,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/core/aip_datapath.sv @@
// Parser datapath: radix register, accumulator, multiply and overflow compare, result register.
`timescale 1ns / 1ps
`default_nettype none

module aip_datapath #(
    parameter int WORD_BITS   = aip_pkg::WORD_BITS_DEF,
    parameter int OFFSET_BITS = aip_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_wr_en,
    input  wire logic [aip_pkg::RADIX_W-1:0]         cfg_wr_data,
    input  wire logic [aip_pkg::CHAR_W-1:0]          ch,
    input  wire logic                                start_req,
    aip_result_if.source                             result_chan,
    input  wire aip_pkg::cmd_t                       cmd,
    output aip_pkg::sts_t                            sts
);

    localparam int PM = WORD_BITS + aip_pkg::RADIX_W;   // product width
    localparam int PS = PM + 1;                         // product plus digit

    localparam logic [1:0] SG_NONE  = 2'd0;
    localparam logic [1:0] SG_PLUS  = 2'd1;
    localparam logic [1:0] SG_MINUS = 2'd2;

    logic [aip_pkg::RADIX_W-1:0] radix_reg;

    // item held between accept and evaluation
    logic [aip_pkg::CHAR_W-1:0]  ch_reg;
    logic                        start_reg;
    logic [PM-1:0]               prod_reg;

    logic [1:0]                  sign_reg, sign_next;
    logic [WORD_BITS-1:0]        acc_reg, acc_next;
    logic [aip_pkg::RADIX_W-1:0] base_reg, base_next;
    logic [OFFSET_BITS-1:0]      idx_reg, idx_next;

    logic                           out_valid_reg, out_valid_next;
    logic [aip_pkg::VALUE_W-1:0]    value_reg;
    logic [aip_pkg::OFFSET_OUT_W-1:0] off_reg;
    logic                           ovf_reg;

    aip_pkg::dig_t               dig;
    logic [1:0]                  sign_eff;
    logic [WORD_BITS-1:0]        acc_eff;
    logic [aip_pkg::RADIX_W-1:0] base_eff;
    logic [OFFSET_BITS-1:0]      idx_eff;
    logic [aip_pkg::RADIX_W-1:0] fc_base;
    logic [aip_pkg::RADIX_W-1:0] zero_base;
    logic [WORD_BITS-1:0]        lim;
    logic [PS-1:0]               sum;
    logic [WORD_BITS-1:0]        mul_a;
    logic                        emitting;
    logic [WORD_BITS-1:0]        emit_w;
    logic [OFFSET_BITS-1:0]      emit_off;
    logic [aip_pkg::VALUE_W-1:0] value_ext;
    logic [OFFSET_BITS+aip_pkg::OFFSET_OUT_W-1:0] off_wide;

    // a start item sees the state as freshly cleared
    assign sign_eff = start_reg ? SG_NONE : sign_reg;
    assign acc_eff  = start_reg ? '0 : acc_reg;
    assign base_eff = start_reg ? '0 : base_reg;
    assign idx_eff  = start_reg ? '0 : idx_reg;

    assign dig       = aip_pkg::digit_of(ch_reg);
    assign fc_base   = (radix_reg == aip_pkg::RADIX_AUTO) ? aip_pkg::DEC_BASE : radix_reg;
    assign zero_base = (base_eff == aip_pkg::RADIX_AUTO) ? aip_pkg::OCT_BASE
                                                         : aip_pkg::HEX_BASE;

    always_comb
    begin
        lim = '1;
        case (sign_eff)
            SG_PLUS:
            begin
                lim[WORD_BITS-1] = 1'b0;
            end
            SG_MINUS:
            begin
                lim = '0;
                lim[WORD_BITS-1] = 1'b1;
            end
            default:
            begin
                lim = '1;
            end
        endcase
    end

    // accum * base + digit > lim, taken at full width, covers both overflow tests
    assign sum = PS'(prod_reg) + PS'(dig.val);

    assign sts.start         = start_reg;
    assign sts.white         = aip_pkg::is_white(ch_reg);
    assign sts.plus          = (ch_reg == aip_pkg::CH_PLUS);
    assign sts.minus         = (ch_reg == aip_pkg::CH_MINUS);
    assign sts.zero_ch       = (ch_reg == aip_pkg::CH_0);
    assign sts.x_ch          = (ch_reg == aip_pkg::CH_UX) || (ch_reg == aip_pkg::CH_LX);
    assign sts.radix_0_or_16 = (radix_reg == aip_pkg::RADIX_AUTO) ||
                               (radix_reg == aip_pkg::HEX_BASE);
    assign sts.use_fc        = aip_pkg::usable(dig, fc_base);
    assign sts.use_zero      = aip_pkg::usable(dig, zero_base);
    assign sts.use_hex       = aip_pkg::usable(dig, aip_pkg::HEX_BASE);
    assign sts.use_used      = aip_pkg::usable(dig, base_eff);
    assign sts.over          = (sum > PS'(lim));
    assign sts.out_stall     = out_valid_reg && !result_chan.ready;

    assign mul_a = start_req ? '0 : acc_reg;

    always_comb
    begin
        sign_next = sign_reg;
        acc_next  = acc_reg;
        base_next = base_reg;
        idx_next  = idx_reg;
        if (cmd.step)
        begin
            case (cmd.sign_op)
                aip_pkg::SGN_PLUS:  sign_next = SG_PLUS;
                aip_pkg::SGN_MINUS: sign_next = SG_MINUS;
                default:            sign_next = sign_eff;
            endcase
            case (cmd.base_op)
                aip_pkg::BASE_FIRST: base_next = fc_base;
                aip_pkg::BASE_RADIX: base_next = radix_reg;
                aip_pkg::BASE_ZERO:  base_next = zero_base;
                aip_pkg::BASE_HEX:   base_next = aip_pkg::HEX_BASE;
                default:             base_next = base_eff;
            endcase
            case (cmd.acc_op)
                aip_pkg::ACC_CLEAR: acc_next = '0;
                aip_pkg::ACC_DIGIT: acc_next = sum[WORD_BITS-1:0];
                default:            acc_next = acc_eff;
            endcase
            if (cmd.idx_inc)
            begin
                idx_next = (idx_eff == {OFFSET_BITS{1'b1}}) ? idx_eff
                                                             : idx_eff + OFFSET_BITS'(1);
            end
            else
            begin
                idx_next = idx_eff;
            end
        end
    end

    always_comb
    begin
        emit_w   = '0;
        emit_off = idx_eff;
        case (cmd.emit_op)
            aip_pkg::EMIT_ZERO:
            begin
                emit_off = '0;
            end
            aip_pkg::EMIT_PLAIN:
            begin
                emit_w = (sign_eff == SG_MINUS) ? ('0 - acc_eff) : acc_eff;
            end
            aip_pkg::EMIT_SAT:
            begin
                emit_w = (sign_eff == SG_MINUS) ? ('0 - lim) : lim;
            end
            aip_pkg::EMIT_HEXFAIL:
            begin
                emit_off = idx_eff - OFFSET_BITS'(1);   // points back at the 'x'
            end
            default:
            begin
                emit_w = '0;
            end
        endcase
        value_ext = {aip_pkg::VALUE_W{emit_w[WORD_BITS-1]}};
        value_ext[WORD_BITS-1:0] = emit_w;
        off_wide = {{aip_pkg::OFFSET_OUT_W{1'b0}}, emit_off};
    end

    assign emitting = cmd.step && (cmd.emit_op != aip_pkg::EMIT_NONE);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emitting)
            out_valid_next = 1'b1;
        else if (out_valid_reg && result_chan.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg     <= aip_pkg::RADIX_AUTO;
            sign_reg      <= SG_NONE;
            acc_reg       <= '0;
            base_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                radix_reg <= cfg_wr_data;
            sign_reg      <= sign_next;
            acc_reg       <= acc_next;
            base_reg      <= base_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ch_reg    <= ch;
            start_reg <= start_req;
            prod_reg  <= PM'(mul_a) * PM'(base_reg);
        end
        if (emitting)
        begin
            value_reg <= value_ext;
            off_reg   <= off_wide[aip_pkg::OFFSET_OUT_W-1:0];
            ovf_reg   <= (cmd.emit_op == aip_pkg::EMIT_SAT);
        end
    end

    assign result_chan.valid       = out_valid_reg;
    assign result_chan.value       = value_reg;
    assign result_chan.stop_offset = off_reg;
    assign result_chan.overflowed  = ovf_reg;

endmodule

`default_nettype wire

@@ rtl/core/aip_ctrl.sv @@
// Parser controller: parse phase state machine and item sequencing.
`timescale 1ns / 1ps
`default_nettype none

module aip_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire aip_pkg::sts_t  sts,
    output aip_pkg::cmd_t       cmd
);

    localparam logic [2:0] PH_DONE   = 3'd0;
    localparam logic [2:0] PH_LEAD   = 3'd1;
    localparam logic [2:0] PH_FIRST  = 3'd2;
    localparam logic [2:0] PH_ZERO   = 3'd3;
    localparam logic [2:0] PH_HEX1   = 3'd4;
    localparam logic [2:0] PH_DIGITS = 3'd5;

    logic [2:0] phase_reg, phase_next;
    logic       busy_reg, busy_next;

    logic [2:0]    ep;
    logic [2:0]    phase_dec;
    aip_pkg::cmd_t dec;
    logic          go_first;
    logic          go_take;
    logic          accept;
    logic          advance;

    assign in_ready = !busy_reg;
    assign accept   = in_valid && !busy_reg;

    always_comb
    begin
        dec          = '0;
        dec.idx_inc  = 1'b1;
        dec.sign_op  = aip_pkg::SGN_KEEP;
        dec.base_op  = aip_pkg::BASE_KEEP;
        dec.acc_op   = aip_pkg::ACC_KEEP;
        dec.emit_op  = aip_pkg::EMIT_NONE;
        go_first     = 1'b0;
        go_take      = 1'b0;
        ep           = sts.start ? PH_LEAD : phase_reg;
        phase_dec    = ep;

        case (ep)
            PH_LEAD:
            begin
                if (sts.white)
                begin
                    phase_dec = PH_LEAD;
                end
                else if (sts.plus)
                begin
                    dec.sign_op = aip_pkg::SGN_PLUS;
                    phase_dec   = PH_FIRST;
                end
                else if (sts.minus)
                begin
                    dec.sign_op = aip_pkg::SGN_MINUS;
                    phase_dec   = PH_FIRST;
                end
                else
                begin
                    go_first = 1'b1;
                end
            end
            PH_FIRST:
            begin
                go_first = 1'b1;
            end
            PH_ZERO:
            begin
                if (sts.x_ch)
                begin
                    dec.base_op = aip_pkg::BASE_HEX;
                    phase_dec   = PH_HEX1;
                end
                else
                begin
                    dec.base_op = aip_pkg::BASE_ZERO;
                    phase_dec   = PH_DIGITS;
                    if (!sts.use_zero)
                        dec.emit_op = aip_pkg::EMIT_PLAIN;
                    else
                        go_take = 1'b1;
                end
            end
            PH_HEX1:
            begin
                if (!sts.use_hex)
                begin
                    dec.acc_op  = aip_pkg::ACC_CLEAR;
                    dec.emit_op = aip_pkg::EMIT_HEXFAIL;
                end
                else
                begin
                    go_take = 1'b1;
                end
            end
            PH_DIGITS:
            begin
                if (!sts.use_used)
                    dec.emit_op = aip_pkg::EMIT_PLAIN;
                else
                    go_take = 1'b1;
            end
            default:
            begin
                // no string open: the item is dropped and the index stays
                dec.idx_inc = 1'b0;
                phase_dec   = PH_DONE;
            end
        endcase

        if (go_first)
        begin
            if (sts.zero_ch && sts.radix_0_or_16)
            begin
                dec.acc_op  = aip_pkg::ACC_CLEAR;
                dec.base_op = aip_pkg::BASE_RADIX;
                phase_dec   = PH_ZERO;
            end
            else
            begin
                dec.base_op = aip_pkg::BASE_FIRST;
                if (!sts.use_fc)
                    dec.emit_op = aip_pkg::EMIT_ZERO;
                else
                    go_take = 1'b1;
            end
        end

        if (go_take)
        begin
            if (sts.over)
            begin
                dec.emit_op = aip_pkg::EMIT_SAT;
            end
            else
            begin
                dec.acc_op = aip_pkg::ACC_DIGIT;
                phase_dec  = PH_DIGITS;
            end
        end

        if (dec.emit_op != aip_pkg::EMIT_NONE)
            phase_dec = PH_DONE;
    end

    // an item that produces a result waits while the result register is still full
    assign advance = busy_reg && !((dec.emit_op != aip_pkg::EMIT_NONE) && sts.out_stall);

    always_comb
    begin
        cmd      = dec;
        cmd.load = accept;
        cmd.step = advance;
    end

    always_comb
    begin
        phase_next = advance ? phase_dec : phase_reg;
        if (accept)
            busy_next = 1'b1;
        else if (advance)
            busy_next = 1'b0;
        else
            busy_next = busy_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_DONE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            busy_reg  <= busy_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/ascii_integer_parser.sv @@
// Top level of the streaming ASCII string-to-integer parser.
//
// char_chan carries one character per item; start_req marks the first
// character of a string. Leading white space and one sign are skipped, the
// base comes from the radix register (0 = detect from a 0x or 0 prefix), and
// digits are accumulated until the first non-digit or an overflow. That item
// produces one result on result_chan: value (sign-extended to 64 bits,
// saturated on overflow), stop_offset and overflowed. Characters after a
// result are dropped until the next start_req.
// The accept edge computes accum * base; the evaluation edge then does the
// add-and-compare against the sign's limit, updates the phase and loads the
// result register. A new character is taken only after the last one has
// been evaluated.
// A full result register only holds up an item that itself produces a
// result; other characters keep flowing while the receiver stalls.
// Reset clears the phase to waiting-for-start and radix to 0. Write radix
// only while no string is being parsed.
`timescale 1ns / 1ps
`default_nettype none

module ascii_integer_parser #(
    parameter int WORD_BITS   = aip_pkg::WORD_BITS_DEF,
    parameter int OFFSET_BITS = aip_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_wr_en,
    input  wire logic [aip_pkg::RADIX_W-1:0] cfg_wr_data,
    aip_char_if.sink                         char_chan,
    aip_result_if.source                     result_chan
);

    aip_pkg::cmd_t cmd;
    aip_pkg::sts_t sts;
    logic          ctl_ready;

    aip_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (char_chan.valid),
        .in_ready (ctl_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    aip_datapath #(
        .WORD_BITS   (WORD_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .ch          (char_chan.ch),
        .start_req   (char_chan.start_req),
        .result_chan (result_chan),
        .cmd         (cmd),
        .sts         (sts)
    );

    assign char_chan.ready = ctl_ready;

endmodule

`default_nettype wire

@@ rtl/core/aip_checker.sv @@
// Port-level assertions for the string-to-integer parser, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

`include "ascii_integer_parser_macros.svh"

module aip_checker #(
    parameter int WORD_BITS = aip_pkg::WORD_BITS_DEF
) (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_valid,
    input wire logic                        in_ready,
    input wire logic                        out_valid,
    input wire logic                        out_ready,
    input wire logic [aip_pkg::VALUE_W-1:0] value,
    input wire logic                        overflowed
);

    localparam logic [aip_pkg::VALUE_W-1:0] SAT_MAX =
        aip_pkg::VALUE_W'((65'd1 << (WORD_BITS - 1)) - 65'd1);
    localparam logic [aip_pkg::VALUE_W-1:0] SAT_MIN  = ~SAT_MAX;
    localparam logic [aip_pkg::VALUE_W-1:0] ALL_ONES = '1;

    logic at_limit;

    assign at_limit = (value == SAT_MAX) || (value == SAT_MIN) || (value == ALL_ONES);

    // ready is low in the cycle after a character is taken, until it has been evaluated
    `AIP_ASSERT_NEXT(a_ready_drops, in_valid && in_ready, !in_ready, "ready high after accept")

    `AIP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped in stall")

    `AIP_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(value), "value moved in stall")

    `AIP_ASSERT_NOW(a_sat_value, out_valid && overflowed, at_limit, "overflow value not a limit")

endmodule

bind ascii_integer_parser aip_checker #(
    .WORD_BITS (WORD_BITS)
) u_aip_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (char_chan.valid),
    .in_ready   (char_chan.ready),
    .out_valid  (result_chan.valid),
    .out_ready  (result_chan.ready),
    .value      (result_chan.value),
    .overflowed (result_chan.overflowed)
);

`default_nettype wire
